FILE: src/batlvl_pkg.sv
// shared types, constants and register map of the battery level block
package batlvl_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 16;
    localparam int PCT_W    = 7;
    localparam int SCNT_W   = 5;
    localparam int VREF_W   = 13;
    localparam int RATIO_W  = 5;

    // shared divider widths: widest numerator is average times vref
    localparam int DIV_W = SAMPLE_W + VREF_W;
    localparam int DEN_W = 16;

    localparam int MAX_SAMPLES_DEF = 16;

    // apb port
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_SAMPLE_COUNT   = 3'd0;
    localparam logic [2:0] REG_VREF_MV        = 3'd1;
    localparam logic [2:0] REG_ADC_FULL_SCALE = 3'd2;
    localparam logic [2:0] REG_DIVIDER_RATIO  = 3'd3;
    localparam logic [2:0] REG_FULL_MV        = 3'd4;
    localparam logic [2:0] REG_EMPTY_MV       = 3'd5;

    // reset values
    localparam logic [SCNT_W-1:0]   RST_SAMPLE_COUNT   = 5'd8;
    localparam logic [VREF_W-1:0]   RST_VREF_MV        = 13'd3300;
    localparam logic [SAMPLE_W-1:0] RST_ADC_FULL_SCALE = 12'd4095;
    localparam logic [RATIO_W-1:0]  RST_DIVIDER_RATIO  = 5'd2;
    localparam logic [MV_W-1:0]     RST_FULL_MV        = 16'd4200;
    localparam logic [MV_W-1:0]     RST_EMPTY_MV       = 16'd3000;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    typedef struct packed {
        logic [SCNT_W-1:0]   sample_count;
        logic [VREF_W-1:0]   vref_mv;
        logic [SAMPLE_W-1:0] adc_full_scale;
        logic [RATIO_W-1:0]  divider_ratio;
        logic [MV_W-1:0]     full_mv;
        logic [MV_W-1:0]     empty_mv;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

endpackage

FILE: src/batlvl_in_if.sv
// input channel: one adc conversion per beat
interface batlvl_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [batlvl_pkg::SAMPLE_W-1:0]      sample;
    logic                                 sample_ok;

    modport source (output valid, output sample, output sample_ok, input ready);
    modport sink   (input valid, input sample, input sample_ok, output ready);
endinterface

FILE: src/batlvl_out_if.sv
// output channel: one battery level result per beat
interface batlvl_out_if;
    logic                             valid;
    logic                             ready;
    logic [batlvl_pkg::SAMPLE_W-1:0]  raw_average;
    logic                             none_valid;
    logic [batlvl_pkg::MV_W-1:0]      battery_mv;
    logic [batlvl_pkg::PCT_W-1:0]     percent;

    modport source (output valid, output raw_average, output none_valid,
                    output battery_mv, output percent, input ready);
    modport sink   (input valid, input raw_average, input none_valid,
                    input battery_mv, input percent, output ready);
endinterface

FILE: src/batlvl_regs.sv
// apb configuration registers
module batlvl_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [batlvl_pkg::APB_AW-1:0]   paddr,
    input  logic [batlvl_pkg::APB_DW-1:0]   pwdata,
    output logic [batlvl_pkg::APB_DW-1:0]   prdata,
    output logic                            pready,
    output batlvl_pkg::t_cfg                o_cfg
);

    batlvl_pkg::t_cfg r_cfg;
    logic [2:0]       w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_count   <= batlvl_pkg::RST_SAMPLE_COUNT;
            r_cfg.vref_mv        <= batlvl_pkg::RST_VREF_MV;
            r_cfg.adc_full_scale <= batlvl_pkg::RST_ADC_FULL_SCALE;
            r_cfg.divider_ratio  <= batlvl_pkg::RST_DIVIDER_RATIO;
            r_cfg.full_mv        <= batlvl_pkg::RST_FULL_MV;
            r_cfg.empty_mv       <= batlvl_pkg::RST_EMPTY_MV;
        end else if (w_wr) begin
            case (w_idx)
                batlvl_pkg::REG_SAMPLE_COUNT: begin
                    r_cfg.sample_count <= pwdata[batlvl_pkg::SCNT_W-1:0];
                end
                batlvl_pkg::REG_VREF_MV: begin
                    r_cfg.vref_mv <= pwdata[batlvl_pkg::VREF_W-1:0];
                end
                batlvl_pkg::REG_ADC_FULL_SCALE: begin
                    r_cfg.adc_full_scale <= pwdata[batlvl_pkg::SAMPLE_W-1:0];
                end
                batlvl_pkg::REG_DIVIDER_RATIO: begin
                    r_cfg.divider_ratio <= pwdata[batlvl_pkg::RATIO_W-1:0];
                end
                batlvl_pkg::REG_FULL_MV: begin
                    r_cfg.full_mv <= pwdata[batlvl_pkg::MV_W-1:0];
                end
                batlvl_pkg::REG_EMPTY_MV: begin
                    r_cfg.empty_mv <= pwdata[batlvl_pkg::MV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            batlvl_pkg::REG_SAMPLE_COUNT:
                prdata = batlvl_pkg::APB_DW'(r_cfg.sample_count);
            batlvl_pkg::REG_VREF_MV:
                prdata = batlvl_pkg::APB_DW'(r_cfg.vref_mv);
            batlvl_pkg::REG_ADC_FULL_SCALE:
                prdata = batlvl_pkg::APB_DW'(r_cfg.adc_full_scale);
            batlvl_pkg::REG_DIVIDER_RATIO:
                prdata = batlvl_pkg::APB_DW'(r_cfg.divider_ratio);
            batlvl_pkg::REG_FULL_MV:
                prdata = batlvl_pkg::APB_DW'(r_cfg.full_mv);
            batlvl_pkg::REG_EMPTY_MV:
                prdata = batlvl_pkg::APB_DW'(r_cfg.empty_mv);
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: src/batlvl_div.sv
// shared restoring divider, one quotient bit per cycle
module batlvl_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  batlvl_pkg::t_div_req  i_req,
    output batlvl_pkg::t_div_rsp  o_rsp
);

    localparam int DIV_W = batlvl_pkg::DIV_W;
    localparam int DEN_W = batlvl_pkg::DEN_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits den width
                r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_quo  <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_busy <= (r_cnt != CNT_W'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: src/battery_level_from_adc_burst_top.sv
// battery level from an adc burst: accumulator, sequencer and output register
// non-final beats of a burst are taken one per cycle and give no result
// the final beat of a burst starts the computation of its result:
// up to three 25-step divisions (mean, pin voltage, percent) on the one shared divider
// input ready is low from the final beat until the result is loaded into the output register
// synchronous active-low reset restores register defaults and clears the burst accumulators
module battery_level_from_adc_burst_top #(
    parameter int MAX_SAMPLES = batlvl_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    batlvl_in_if.sink                       i_in,
    batlvl_out_if.source                    o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [batlvl_pkg::APB_AW-1:0]   paddr,
    input  logic [batlvl_pkg::APB_DW-1:0]   pwdata,
    output logic [batlvl_pkg::APB_DW-1:0]   prdata,
    output logic                            pready
);

    localparam int SAMPLE_W = batlvl_pkg::SAMPLE_W;
    localparam int MV_W     = batlvl_pkg::MV_W;
    localparam int PCT_W    = batlvl_pkg::PCT_W;
    localparam int DIV_W    = batlvl_pkg::DIV_W;
    localparam int DEN_W    = batlvl_pkg::DEN_W;
    localparam int SCNT_W   = batlvl_pkg::SCNT_W;
    // accumulator holds a full burst of maximum codes
    localparam int SUM_W    = $clog2(4095 * MAX_SAMPLES + 1);
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int LEN_W    = (CNT_W > SCNT_W) ? CNT_W : SCNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_AVG,
        S_MUL_PIN,
        S_DIV_PIN,
        S_MUL_MV,
        S_PCT,
        S_DIV_PCT,
        S_OUT
    } t_state;

    batlvl_pkg::t_cfg     w_cfg;
    batlvl_pkg::t_div_rsp w_div_rsp;

    // control
    t_state               r_state, n_state;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_seen, n_seen;
    logic [CNT_W-1:0]     r_good, n_good;
    batlvl_pkg::t_div_req r_div_req, n_div_req;
    logic                 r_out_valid, n_out_valid;

    // datapath
    logic [SAMPLE_W-1:0]  r_avg, n_avg;
    logic                 r_none, n_none;
    logic [DIV_W-1:0]     r_pin, n_pin;
    logic [MV_W-1:0]      r_mv, n_mv;
    logic [PCT_W-1:0]     r_pct, n_pct;
    logic [SAMPLE_W-1:0]  r_out_avg, n_out_avg;
    logic                 r_out_none, n_out_none;
    logic [MV_W-1:0]      r_out_mv, n_out_mv;
    logic [PCT_W-1:0]     r_out_pct, n_out_pct;

    // burst bookkeeping
    logic                 w_accept;
    logic [SUM_W-1:0]     w_sum_next;
    logic [CNT_W-1:0]     w_seen_next;
    logic [CNT_W-1:0]     w_good_next;
    logic [LEN_W-1:0]     w_sc_ext;
    logic [LEN_W-1:0]     w_len;
    logic                 w_last;

    // arithmetic feeding the divider
    logic [SAMPLE_W-1:0]  w_scale;
    logic [DIV_W-1:0]     w_prod_pin;
    logic [DIV_W-1:0]     w_prod_mv;
    logic [MV_W-1:0]      w_span;
    logic [MV_W-1:0]      w_over;
    logic [DIV_W-1:0]     w_pct_num;

    batlvl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    batlvl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    // input side: one beat per cycle while the sequencer is idle
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;

    assign w_sum_next  = r_sum + (i_in.sample_ok ? SUM_W'(i_in.sample) : '0);
    assign w_good_next = r_good + (i_in.sample_ok ? CNT_W'(1) : '0);
    assign w_seen_next = r_seen + CNT_W'(1);

    // effective burst length: zero acts as one, clipped to the maximum
    assign w_sc_ext = LEN_W'(w_cfg.sample_count);
    always_comb begin
        if (w_sc_ext == '0) begin
            w_len = LEN_W'(1);
        end else if (w_sc_ext > LEN_W'(MAX_SAMPLES)) begin
            w_len = LEN_W'(MAX_SAMPLES);
        end else begin
            w_len = w_sc_ext;
        end
    end
    // a shortened length mid-burst ends the burst at once
    assign w_last = (LEN_W'(w_seen_next) >= w_len);

    // zero full scale acts as one
    assign w_scale    = (w_cfg.adc_full_scale == '0) ? SAMPLE_W'(1)
                                                     : w_cfg.adc_full_scale;
    assign w_prod_pin = DIV_W'(r_avg) * DIV_W'(w_cfg.vref_mv);
    assign w_prod_mv  = r_pin * DIV_W'(w_cfg.divider_ratio);
    assign w_span     = w_cfg.full_mv - w_cfg.empty_mv;
    assign w_over     = r_mv - w_cfg.empty_mv;
    assign w_pct_num  = DIV_W'(w_over) * DIV_W'(batlvl_pkg::PCT_FULL);

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_seen      = r_seen;
        n_good      = r_good;
        n_div_req   = r_div_req;
        n_out_valid = r_out_valid;
        n_avg       = r_avg;
        n_none      = r_none;
        n_pin       = r_pin;
        n_mv        = r_mv;
        n_pct       = r_pct;
        n_out_avg   = r_out_avg;
        n_out_none  = r_out_none;
        n_out_mv    = r_out_mv;
        n_out_pct   = r_out_pct;

        // start is a one-cycle pulse
        n_div_req.start = 1'b0;

        // result taken downstream
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_last) begin
                        n_sum  = '0;
                        n_seen = '0;
                        n_good = '0;
                        n_none = (w_good_next == '0);
                        if (w_good_next == '0) begin
                            n_avg   = '0;
                            n_state = S_MUL_PIN;
                        end else begin
                            n_div_req.start = 1'b1;
                            n_div_req.num   = DIV_W'(w_sum_next);
                            n_div_req.den   = DEN_W'(w_good_next);
                            n_state         = S_DIV_AVG;
                        end
                    end else begin
                        n_sum  = w_sum_next;
                        n_seen = w_seen_next;
                        n_good = w_good_next;
                    end
                end
            end
            S_DIV_AVG: begin
                if (w_div_rsp.done) begin
                    n_avg   = w_div_rsp.quo[SAMPLE_W-1:0];
                    n_state = S_MUL_PIN;
                end
            end
            S_MUL_PIN: begin
                // product lands in the divider's dividend register
                n_div_req.start = 1'b1;
                n_div_req.num   = w_prod_pin;
                n_div_req.den   = DEN_W'(w_scale);
                n_state         = S_DIV_PIN;
            end
            S_DIV_PIN: begin
                if (w_div_rsp.done) begin
                    n_pin   = w_div_rsp.quo;
                    n_state = S_MUL_MV;
                end
            end
            S_MUL_MV: begin
                n_mv    = w_prod_mv[MV_W-1:0];
                n_state = S_PCT;
            end
            S_PCT: begin
                // full limit wins over empty when the limits are out of order
                if (r_mv >= w_cfg.full_mv) begin
                    n_pct   = batlvl_pkg::PCT_FULL;
                    n_state = S_OUT;
                end else if (r_mv <= w_cfg.empty_mv) begin
                    n_pct   = batlvl_pkg::PCT_EMPTY;
                    n_state = S_OUT;
                end else begin
                    n_div_req.start = 1'b1;
                    n_div_req.num   = w_pct_num;
                    n_div_req.den   = w_span;
                    n_state         = S_DIV_PCT;
                end
            end
            S_DIV_PCT: begin
                if (w_div_rsp.done) begin
                    n_pct   = w_div_rsp.quo[PCT_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // load once the output register is free or being drained
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_avg;
                    n_out_none  = r_none;
                    n_out_mv    = r_mv;
                    n_out_pct   = r_pct;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_sum           <= '0;
            r_seen          <= '0;
            r_good          <= '0;
            r_div_req.start <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_seen      <= n_seen;
            r_good      <= n_good;
            r_div_req   <= n_div_req;
            r_out_valid <= n_out_valid;
            r_avg       <= n_avg;
            r_none      <= n_none;
            r_pin       <= n_pin;
            r_mv        <= n_mv;
            r_pct       <= n_pct;
            r_out_avg   <= n_out_avg;
            r_out_none  <= n_out_none;
            r_out_mv    <= n_out_mv;
            r_out_pct   <= n_out_pct;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.raw_average = r_out_avg;
    assign o_out.none_valid  = r_out_none;
    assign o_out.battery_mv  = r_out_mv;
    assign o_out.percent     = r_out_pct;

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the battery level from adc burst block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = batlvl_pkg::SAMPLE_W;
    localparam int MV_W     = batlvl_pkg::MV_W;
    localparam int PCT_W    = batlvl_pkg::PCT_W;
    localparam int SCNT_W   = batlvl_pkg::SCNT_W;
    localparam int VREF_W   = batlvl_pkg::VREF_W;
    localparam int RATIO_W  = batlvl_pkg::RATIO_W;
    localparam int APB_AW   = batlvl_pkg::APB_AW;
    localparam int APB_DW   = batlvl_pkg::APB_DW;

    // spare register slots above the map, writes there must change nothing
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int unsigned PERCENT_SCALE = 100;
    // settle time after the last reading, with some margin
    localparam int unsigned SETTLE_CYCLES = 100;
    // long receiver hold-off used to back the block up
    localparam int unsigned HOLD_CYCLES   = 400;
    // cycles with no beat, no result and no register access before giving up
    localparam int unsigned STALL_LIMIT   = 4000;

    // one expected result beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_average;
        logic                none_valid;
        logic [MV_W-1:0]     battery_mv;
        logic [PCT_W-1:0]    percent;
    } t_battery_reading;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    batlvl_in_if  in_ch ();
    batlvl_out_if out_ch ();

    battery_level_from_adc_burst_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the register file, kept in step with every write
    batlvl_pkg::t_cfg cfg_shadow;

    // running burst state of the predictor
    logic [15:0]       burst_sum;
    logic [SCNT_W-1:0] burst_seen;
    logic [SCNT_W-1:0] burst_good;

    t_battery_reading expected_readings[$];
    int unsigned      error_count;

    // idling knobs, in percent per cycle
    int unsigned sender_idle_pct;
    int unsigned sink_stall_pct;

    // hold-off request: bump hold_seq after setting hold_len
    int unsigned hold_len;
    int unsigned hold_seq;

    // -------------------------------------------------------------------
    // clock
    // -------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------
    // predictor
    // -------------------------------------------------------------------

    // effective burst length: zero acts as one, clamp at the maximum
    function automatic int unsigned burst_span(input batlvl_pkg::t_cfg c);
        int unsigned n;
        n = 32'(c.sample_count);
        if (n == 0) n = 1;
        if (n > batlvl_pkg::MAX_SAMPLES_DEF) n = batlvl_pkg::MAX_SAMPLES_DEF;
        return n;
    endfunction

    // mean, battery voltage and charge level for one completed burst
    function automatic t_battery_reading battery_reading(input logic [15:0] sum,
                                                         input logic [SCNT_W-1:0] good,
                                                         input batlvl_pkg::t_cfg c);
        t_battery_reading r;
        logic [31:0] mean;
        logic [31:0] divisor;
        logic [31:0] pin_mv;
        logic [31:0] bat_mv;
        logic [31:0] level;
        if (good == '0) mean = 32'd0;
        else mean = 32'(sum) / 32'(good);
        mean = mean & 32'hFFF;
        // zero full scale acts as one
        if (c.adc_full_scale == '0) divisor = 32'd1;
        else divisor = 32'(c.adc_full_scale);
        pin_mv = (mean * 32'(c.vref_mv)) / divisor;
        bat_mv = (pin_mv * 32'(c.divider_ratio)) & 32'hFFFF;
        // full limit wins first, so limits out of order never divide by zero
        if (bat_mv >= 32'(c.full_mv)) level = 32'(batlvl_pkg::PCT_FULL);
        else if (bat_mv <= 32'(c.empty_mv)) level = 32'(batlvl_pkg::PCT_EMPTY);
        else level = ((bat_mv - 32'(c.empty_mv)) * PERCENT_SCALE)
                     / (32'(c.full_mv) - 32'(c.empty_mv));
        r.raw_average = mean[SAMPLE_W-1:0];
        r.none_valid  = (good == '0);
        r.battery_mv  = bat_mv[MV_W-1:0];
        r.percent     = level[PCT_W-1:0];
        return r;
    endfunction

    // every accepted conversion beat advances the burst, the last one queues a reading
    always @(posedge i_clk) begin : burst_predictor
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            // a failed conversion still counts toward the burst length
            if (in_ch.sample_ok) begin
                burst_sum  = burst_sum + 16'(in_ch.sample);
                burst_good = burst_good + SCNT_W'(1);
            end
            burst_seen = burst_seen + SCNT_W'(1);
            if (32'(burst_seen) >= burst_span(cfg_shadow)) begin
                expected_readings.push_back(battery_reading(burst_sum, burst_good,
                                                            cfg_shadow));
                burst_sum  = '0;
                burst_seen = '0;
                burst_good = '0;
            end
        end
    end

    // -------------------------------------------------------------------
    // result checker
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin : reading_checker
        t_battery_reading want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_readings.size() == 0) begin
                $error("result beat with none expected: raw_average %0d battery_mv %0d",
                       out_ch.raw_average, out_ch.battery_mv);
                error_count++;
            end else begin
                want = expected_readings.pop_front();
                if (out_ch.raw_average !== want.raw_average) begin
                    $error("raw_average: expected %0d, got %0d",
                           want.raw_average, out_ch.raw_average);
                    error_count++;
                end
                if (out_ch.none_valid !== want.none_valid) begin
                    $error("none_valid: expected %0d, got %0d",
                           want.none_valid, out_ch.none_valid);
                    error_count++;
                end
                if (out_ch.battery_mv !== want.battery_mv) begin
                    $error("battery_mv: expected %0d, got %0d",
                           want.battery_mv, out_ch.battery_mv);
                    error_count++;
                end
                if (out_ch.percent !== want.percent) begin
                    $error("percent: expected %0d, got %0d", want.percent, out_ch.percent);
                    error_count++;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // result receiver: random stalls, plus a counted hold-off on request
    // -------------------------------------------------------------------
    initial begin : result_receiver
        int unsigned hold_left;
        int unsigned seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // -------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // -------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench: done, errors");
        $finish;
    end

    // -------------------------------------------------------------------
    // shared drivers
    // -------------------------------------------------------------------

    // apb write: setup, access, then back to idle
    task automatic write_register(input logic [2:0] index, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // registers take the low bits only, spare slots are ignored
        case (index)
            batlvl_pkg::REG_SAMPLE_COUNT:
                cfg_shadow.sample_count   = value[SCNT_W-1:0];
            batlvl_pkg::REG_VREF_MV:
                cfg_shadow.vref_mv        = value[VREF_W-1:0];
            batlvl_pkg::REG_ADC_FULL_SCALE:
                cfg_shadow.adc_full_scale = value[SAMPLE_W-1:0];
            batlvl_pkg::REG_DIVIDER_RATIO:
                cfg_shadow.divider_ratio  = value[RATIO_W-1:0];
            batlvl_pkg::REG_FULL_MV:
                cfg_shadow.full_mv        = value[MV_W-1:0];
            batlvl_pkg::REG_EMPTY_MV:
                cfg_shadow.empty_mv       = value[MV_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one conversion beat, with random idle cycles ahead of it
    task automatic send_conversion(input logic [SAMPLE_W-1:0] value, input logic ok);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= value;
        in_ch.sample_ok <= ok;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // drop valid, wait for every reading, then let the divider settle
    task automatic wait_until_idle();
        in_ch.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sample values biased toward the ends of the range
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(4095));
        endcase
    endfunction

    // -------------------------------------------------------------------
    // directed tests
    // -------------------------------------------------------------------

    // reset values, both ends of the sample range, failed conversions mixed in
    task automatic test_default_burst();
        send_conversion(12'd4095, 1'b1);
        send_conversion(12'd0,    1'b1);
        send_conversion(12'd4095, 1'b0);
        send_conversion(12'd2600, 1'b1);
        send_conversion(12'd2600, 1'b1);
        send_conversion(12'd0,    1'b0);
        send_conversion(12'd4095, 1'b1);
        send_conversion(12'd2700, 1'b1);
        wait_until_idle();
    endtask

    // every conversion of the burst failed: zero mean with the flag set
    task automatic test_all_failed();
        write_register(batlvl_pkg::REG_SAMPLE_COUNT, 2);
        send_conversion(12'd4095, 1'b0);
        send_conversion(12'd0,    1'b0);
        wait_until_idle();
    endtask

    // burst length zero acts as one
    task automatic test_burst_length_zero();
        write_register(batlvl_pkg::REG_SAMPLE_COUNT, 0);
        send_conversion(12'd4095, 1'b1);
        wait_until_idle();
    endtask

    // zero full scale acts as one, vref and ratio at their maximum
    task automatic test_zero_full_scale();
        write_register(batlvl_pkg::REG_ADC_FULL_SCALE, 0);
        write_register(batlvl_pkg::REG_VREF_MV, 8191);
        write_register(batlvl_pkg::REG_DIVIDER_RATIO, 31);
        send_conversion(12'd4095, 1'b1);
        wait_until_idle();
    endtask

    // percent clamping with limits reversed, equal, and at the register extremes
    task automatic test_percent_limits();
        write_register(batlvl_pkg::REG_ADC_FULL_SCALE, 4095);
        write_register(batlvl_pkg::REG_VREF_MV, 3300);
        write_register(batlvl_pkg::REG_DIVIDER_RATIO, 2);
        write_register(batlvl_pkg::REG_FULL_MV, 1000);
        write_register(batlvl_pkg::REG_EMPTY_MV, 5000);
        send_conversion(12'd2048, 1'b1);
        send_conversion(12'd0,    1'b1);
        wait_until_idle();
        write_register(batlvl_pkg::REG_FULL_MV, 3000);
        write_register(batlvl_pkg::REG_EMPTY_MV, 3000);
        send_conversion(12'd2048, 1'b1);
        wait_until_idle();
        write_register(batlvl_pkg::REG_FULL_MV, 65535);
        write_register(batlvl_pkg::REG_EMPTY_MV, 0);
        send_conversion(12'd4095, 1'b1);
        wait_until_idle();
    endtask

    // shorten the burst while one is half done: it ends on the next beat
    task automatic test_burst_length_change();
        write_register(batlvl_pkg::REG_SAMPLE_COUNT, 4);
        send_conversion(12'd1000, 1'b1);
        send_conversion(12'd3000, 1'b0);
        wait_until_idle();
        write_register(batlvl_pkg::REG_SAMPLE_COUNT, 2);
        send_conversion(12'd2000, 1'b1);
        wait_until_idle();
    endtask

    // writes beyond the register map leave everything as it was
    task automatic test_spare_registers();
        write_register(REG_SPARE_LO, '1);
        write_register(REG_SPARE_HI, '1);
        send_conversion(12'd4095, 1'b1);
        send_conversion(12'd1,    1'b1);
        wait_until_idle();
    endtask

    // receiver holds off for a long stretch while beats keep coming,
    // so the output register fills and the input has to stall
    task automatic test_output_backpressure();
        int unsigned i;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        write_register(batlvl_pkg::REG_SAMPLE_COUNT, 1);
        hold_len = HOLD_CYCLES;
        hold_seq++;
        for (i = 0; i < 12; i++) send_conversion(random_sample(), 1'b1);
        wait_until_idle();
    endtask

    // -------------------------------------------------------------------
    // random tests
    // -------------------------------------------------------------------

    // new values for all six registers: mostly realistic, some full range, some extremes
    task automatic program_random_settings();
        logic [31:0] count;
        logic [31:0] vref;
        logic [31:0] scale;
        logic [31:0] ratio;
        logic [31:0] full;
        logic [31:0] empty;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50) count = $urandom_range(1, 4);
        else if (pick < 70) count = $urandom_range(5, 16);
        else if (pick < 80) count = 0;
        else if (pick < 90) count = $urandom_range(17, 31);
        else count = 16;
        pick = $urandom_range(99);
        if (pick < 70) begin
            // realistic divider with the battery window somewhere in reach
            vref  = $urandom_range(1000, 5000);
            scale = $urandom_range(1000, 4095);
            ratio = $urandom_range(1, 4);
            empty = $urandom_range(0, 8000);
            full  = empty + $urandom_range(1, 12000);
        end else if (pick < 85) begin
            // whole field ranges, limits in any order
            vref  = $urandom_range(8191);
            scale = $urandom_range(4095);
            ratio = $urandom_range(31);
            full  = $urandom_range(65535);
            empty = $urandom_range(65535);
        end else begin
            vref  = $urandom_range(1) ? 0 : 8191;
            case ($urandom_range(2))
                0:       scale = 0;
                1:       scale = 1;
                default: scale = 4095;
            endcase
            case ($urandom_range(2))
                0:       ratio = 0;
                1:       ratio = 1;
                default: ratio = 31;
            endcase
            full  = $urandom_range(1) ? 0 : 65535;
            empty = $urandom_range(1) ? 0 : 65535;
        end
        write_register(batlvl_pkg::REG_SAMPLE_COUNT, count);
        write_register(batlvl_pkg::REG_VREF_MV, vref);
        write_register(batlvl_pkg::REG_ADC_FULL_SCALE, scale);
        write_register(batlvl_pkg::REG_DIVIDER_RATIO, ratio);
        write_register(batlvl_pkg::REG_FULL_MV, full);
        write_register(batlvl_pkg::REG_EMPTY_MV, empty);
    endtask

    // whole bursts with random content under one idling setting,
    // new register values every few dozen beats, now and then a stray beat
    task automatic test_random_bursts(input int unsigned item_total,
                                      input int unsigned idle_pct,
                                      input int unsigned stall_pct);
        int unsigned sent;
        int unsigned chunk;
        int unsigned span;
        int unsigned flavor;
        int unsigned i;
        logic        ok;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        sent = 0;
        while (sent < item_total) begin
            wait_until_idle();
            program_random_settings();
            span  = burst_span(cfg_shadow);
            chunk = $urandom_range(30, 80);
            while (chunk > 0) begin
                // mostly good bursts, some all failed, some half failed
                flavor = $urandom_range(99);
                for (i = 0; i < span; i++) begin
                    if (flavor < 15) ok = 1'b0;
                    else if (flavor < 30) ok = 1'($urandom_range(1));
                    else ok = ($urandom_range(9) != 0);
                    send_conversion(random_sample(), ok);
                end
                sent  += span;
                chunk  = (chunk > span) ? chunk - span : 0;
            end
            // stray beat leaves a partial burst across the next register change
            if ($urandom_range(3) == 0) begin
                send_conversion(random_sample(), 1'($urandom_range(1)));
                sent++;
            end
        end
        wait_until_idle();
    endtask

    // -------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------
    initial begin
        error_count     = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        hold_len        = 0;
        hold_seq        = 0;
        burst_sum       = '0;
        burst_seen      = '0;
        burst_good      = '0;
        cfg_shadow.sample_count   = batlvl_pkg::RST_SAMPLE_COUNT;
        cfg_shadow.vref_mv        = batlvl_pkg::RST_VREF_MV;
        cfg_shadow.adc_full_scale = batlvl_pkg::RST_ADC_FULL_SCALE;
        cfg_shadow.divider_ratio  = batlvl_pkg::RST_DIVIDER_RATIO;
        cfg_shadow.full_mv        = batlvl_pkg::RST_FULL_MV;
        cfg_shadow.empty_mv       = batlvl_pkg::RST_EMPTY_MV;

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample    <= '0;
        in_ch.sample_ok <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_burst();
        test_all_failed();
        test_burst_length_zero();
        test_zero_full_scale();
        test_percent_limits();
        test_burst_length_change();
        test_spare_registers();
        test_output_backpressure();

        // no idling, sender idle, receiver stalling, both
        test_random_bursts(300, 0, 0);
        test_random_bursts(300, 76, 0);
        test_random_bursts(300, 0, 76);
        test_random_bursts(300, 15, 15);

        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/batlvl_pkg.sv
src/batlvl_in_if.sv
src/batlvl_out_if.sv
src/batlvl_regs.sv
src/batlvl_div.sv
src/battery_level_from_adc_burst_top.sv
verif/testbench.sv
